// ===== design/rtpk_pkg.sv =====
// Shared types and constants for the RTP audio packetizer.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package rtpk_pkg;

	// Field widths.
	localparam int BYTE_W  = 8;
	localparam int PT_W    = 7;
	localparam int SEQ_W   = 16;
	localparam int TS_W    = 32;
	localparam int SSRC_W  = 32;
	localparam int CNT_W   = 12;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 5;

	// Packet size limit and queue depth defaults.
	localparam int MAX_PAYLOAD_BYTES = 4095;
	localparam int QUEUE_DEPTH       = 4;

	// Header layout.
	localparam int HDR_BYTES = 12;
	localparam logic [BYTE_W-1:0] RTP_BYTE0 = 8'h80;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ENABLE       = 3'd0,
		REG_PAYLOAD_TYPE = 3'd1,
		REG_SSRC         = 3'd2,
		REG_BYTES_PKT    = 3'd3,
		REG_SAMPLES_PKT  = 3'd4
	} reg_idx_t;

	// Reset values of the payload type, byte count and sample count registers.
	localparam logic [PT_W-1:0]  PT_RESET      = 7'd96;
	localparam logic [CNT_W-1:0] BYTES_RESET   = 12'd288;
	localparam logic [CNT_W-1:0] SAMPLES_RESET = 12'd48;

	// Settings the front end uses to classify items.
	typedef struct packed {
		logic             enable;
		logic [CNT_W-1:0] pkt_bytes;
		logic [CNT_W-1:0] pkt_samples;
	} front_cfg_t;

	// Settings the back end uses to build headers.
	typedef struct packed {
		logic [PT_W-1:0]   ptype;
		logic [SSRC_W-1:0] ssrc;
	} back_cfg_t;

	// One classified item: payload byte, packet marks and header values.
	typedef struct packed {
		logic              hdr;
		logic [SEQ_W-1:0]  seq;
		logic [TS_W-1:0]   ts;
		logic [BYTE_W-1:0] data;
		logic              pkt_end;
		logic              pkt_abort;
	} cmd_t;

	// Header byte at position idx (0 to HDR_BYTES-1), big-endian fields.
	function automatic logic [BYTE_W-1:0] hdr_byte(
		input logic [3:0]        idx,
		input logic [PT_W-1:0]   pt,
		input logic [SEQ_W-1:0]  seq,
		input logic [TS_W-1:0]   ts,
		input logic [SSRC_W-1:0] ssrc
	);
		logic [HDR_BYTES*BYTE_W-1:0] vec;
		logic [3:0]                  pos;
		vec = {RTP_BYTE0, 1'b0, pt, seq, ts, ssrc};
		pos = 4'(HDR_BYTES - 1) - idx;
		return vec[{pos, 3'b000} +: BYTE_W];
	endfunction

endpackage

`default_nettype wire

// ===== design/rtpk_front.sv =====
// Front end: accepts input items, tracks packet state and classifies each item.
// Depends on rtpk_pkg; writes one command per enabled item into the queue.
`default_nettype none

module rtpk_front #(
	parameter int MAX_PAYLOAD_BYTES = rtpk_pkg::MAX_PAYLOAD_BYTES
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [rtpk_pkg::BYTE_W-1:0] payload_byte,
	input  wire logic                        buffer_first,
	input  wire logic                        buffer_last,
	input  wire logic                        ptp_valid,
	input  wire logic [rtpk_pkg::TS_W-1:0]   ptp_time,
	input  wire rtpk_pkg::front_cfg_t        cfg,
	output      logic                        wr_en,
	output      rtpk_pkg::cmd_t              wr_cmd
);

	logic [rtpk_pkg::SEQ_W-1:0] seq_q;
	logic [rtpk_pkg::TS_W-1:0]  rtp_time_q;
	logic [rtpk_pkg::CNT_W-1:0] count_q;
	logic                       in_packet_q;

	logic [rtpk_pkg::CNT_W-1:0] lim;
	logic [rtpk_pkg::CNT_W-1:0] cnt_next;
	logic [rtpk_pkg::TS_W-1:0]  ts_cur;
	logic                       full_pkt;
	logic                       close_pkt;

	// Packet size: zero acts as one, and the size is capped at the maximum.
	always_comb begin
		if (cfg.pkt_bytes == '0) begin
			lim = rtpk_pkg::CNT_W'(1);
		end else if ({5'b0, cfg.pkt_bytes} > 17'(MAX_PAYLOAD_BYTES)) begin
			lim = rtpk_pkg::CNT_W'(MAX_PAYLOAD_BYTES);
		end else begin
			lim = cfg.pkt_bytes;
		end
	end

	// Classify the item against the open packet.
	assign cnt_next  = (in_packet_q ? count_q : '0) + rtpk_pkg::CNT_W'(1);
	assign ts_cur    = (!in_packet_q && buffer_first && ptp_valid) ? ptp_time : rtp_time_q;
	assign full_pkt  = (cnt_next >= lim);
	assign close_pkt = full_pkt || buffer_last;

	assign wr_en            = accept && cfg.enable;
	assign wr_cmd.hdr       = !in_packet_q;
	assign wr_cmd.seq       = seq_q;
	assign wr_cmd.ts        = ts_cur;
	assign wr_cmd.data      = payload_byte;
	assign wr_cmd.pkt_end   = close_pkt;
	assign wr_cmd.pkt_abort = !full_pkt && buffer_last;

	// Packet state update for each enabled item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= '0;
			rtp_time_q  <= '0;
			count_q     <= '0;
			in_packet_q <= 1'b0;
		end else if (wr_en) begin
			if (full_pkt) begin
				seq_q      <= seq_q + rtpk_pkg::SEQ_W'(1);
				rtp_time_q <= ts_cur + {20'b0, cfg.pkt_samples};
			end else begin
				rtp_time_q <= ts_cur;
			end
			in_packet_q <= !close_pkt;
			count_q     <= close_pkt ? '0 : cnt_next;
		end
	end

endmodule

`default_nettype wire

// ===== design/rtpk_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on rtpk_pkg for the command type.
`default_nettype none

module rtpk_queue #(
	parameter int DEPTH = rtpk_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire rtpk_pkg::cmd_t wr_cmd,
	input  wire logic           rd_en,
	output      rtpk_pkg::cmd_t rd_cmd,
	output      logic           q_full,
	output      logic           q_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rtpk_pkg::cmd_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_cmd  = slot_q[rd_ptr_q];

	// Storage slots carry no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/rtpk_back.sv =====
// Back end: expands each queued command into its payload byte, preceded by header bytes when it opens a packet.
// Depends on rtpk_pkg; drives the output register of the result channel.
`default_nettype none

module rtpk_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rtpk_pkg::back_cfg_t         cfg,
	input  wire rtpk_pkg::cmd_t              head,
	input  wire logic                        q_empty,
	output      logic                        rd_en,
	input  wire logic                        pop,
	output      logic                        empty,
	output      logic [rtpk_pkg::BYTE_W-1:0] out_byte,
	output      logic                        header_byte,
	output      logic                        packet_end,
	output      logic                        packet_abort
);

	logic [3:0]                  phase_q;
	logic                        out_v_q;
	logic [rtpk_pkg::BYTE_W-1:0] byte_q;
	logic                        hdr_q;
	logic                        end_q;
	logic                        abort_q;

	logic                        load;
	logic                        in_hdr;
	logic [rtpk_pkg::BYTE_W-1:0] hbyte;

	// The output register takes a new result when it is free or being emptied.
	assign load   = !q_empty && (!out_v_q || pop);
	assign in_hdr = head.hdr && (phase_q != 4'(rtpk_pkg::HDR_BYTES));
	assign rd_en  = load && !in_hdr;
	assign hbyte  = rtpk_pkg::hdr_byte(phase_q, cfg.ptype, head.seq, head.ts,
		cfg.ssrc);

	// Header position counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q <= in_hdr ? phase_q + 4'd1 : '0;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= in_hdr ? hbyte : head.data;
			hdr_q   <= in_hdr;
			end_q   <= !in_hdr && head.pkt_end;
			abort_q <= !in_hdr && head.pkt_abort;
		end
	end

	assign empty        = !out_v_q;
	assign out_byte     = byte_q;
	assign header_byte  = hdr_q;
	assign packet_end   = end_q;
	assign packet_abort = abort_q;

endmodule

`default_nettype wire

// ===== design/rtp_audio_packetizer.sv =====
// RTP audio packetizer: top level with configuration registers.
// Instantiates rtpk_front, rtpk_queue and rtpk_back; depends on rtpk_pkg.
//
// Usage: audio payload bytes enter on a queue-style port (push/full) with
// buffer_first, buffer_last, ptp_valid and ptp_time. An item is taken when
// push is high and full is low. Results leave on a queue-style port: while
// empty is low the oldest result is on out_byte, header_byte, packet_end and
// packet_abort, and pop takes it.
// The first item of a packet yields 13 results (12 header bytes and the
// payload byte); every other item yields one. Items enter at one per cycle
// while full is low into a command queue of QUEUE_DEPTH entries; the back
// end emits one result per cycle while the receiver keeps popping. The first
// result of an item is written to the command queue and then loaded into the
// output register. When the receiver stalls, results wait in the output
// register, the queue fills, and full rises; nothing is lost. With enable
// low, items are taken and dropped. Reset clears the queue, sequence number,
// timestamp and packet state, and loads the register defaults. Registers sit
// at 4*index on the APB port; the user must write them only while the block
// is idle, as the block itself does not enforce it.
`default_nettype none

module rtp_audio_packetizer #(
	parameter int MAX_PAYLOAD_BYTES = rtpk_pkg::MAX_PAYLOAD_BYTES,
	parameter int QUEUE_DEPTH       = rtpk_pkg::QUEUE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rtpk_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [rtpk_pkg::DATA_W-1:0]   pwdata,
	output      logic [rtpk_pkg::DATA_W-1:0]   prdata,
	output      logic                          pready,
	input  wire logic                          push,
	output      logic                          full,
	input  wire logic [rtpk_pkg::BYTE_W-1:0]   payload_byte,
	input  wire logic                          buffer_first,
	input  wire logic                          buffer_last,
	input  wire logic                          ptp_valid,
	input  wire logic [rtpk_pkg::TS_W-1:0]     ptp_time,
	output      logic                          empty,
	input  wire logic                          pop,
	output      logic [rtpk_pkg::BYTE_W-1:0]   out_byte,
	output      logic                          header_byte,
	output      logic                          packet_end,
	output      logic                          packet_abort
);

	logic                          enable_q;
	logic [rtpk_pkg::PT_W-1:0]     pt_q;
	logic [rtpk_pkg::SSRC_W-1:0]   ssrc_q;
	logic [rtpk_pkg::CNT_W-1:0]    bpp_q;
	logic [rtpk_pkg::CNT_W-1:0]    spp_q;

	rtpk_pkg::reg_idx_t  reg_idx;
	logic                reg_wr;
	rtpk_pkg::front_cfg_t front_cfg;
	rtpk_pkg::back_cfg_t  back_cfg;
	rtpk_pkg::cmd_t       wr_cmd;
	rtpk_pkg::cmd_t       head;
	logic                 wr_en;
	logic                 rd_en;
	logic                 q_full;
	logic                 q_empty;
	logic                 accept;

	// Configuration port decode.
	assign pready  = 1'b1;
	assign reg_idx = rtpk_pkg::reg_idx_t'(paddr[4:2]);
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			pt_q     <= rtpk_pkg::PT_RESET;
			ssrc_q   <= '0;
			bpp_q    <= rtpk_pkg::BYTES_RESET;
			spp_q    <= rtpk_pkg::SAMPLES_RESET;
		end else if (reg_wr) begin
			case (reg_idx)
				rtpk_pkg::REG_ENABLE:       enable_q <= pwdata[0];
				rtpk_pkg::REG_PAYLOAD_TYPE: pt_q     <= pwdata[rtpk_pkg::PT_W-1:0];
				rtpk_pkg::REG_SSRC:         ssrc_q   <= pwdata;
				rtpk_pkg::REG_BYTES_PKT:    bpp_q    <= pwdata[rtpk_pkg::CNT_W-1:0];
				rtpk_pkg::REG_SAMPLES_PKT:  spp_q    <= pwdata[rtpk_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			rtpk_pkg::REG_ENABLE:       prdata = {31'b0, enable_q};
			rtpk_pkg::REG_PAYLOAD_TYPE: prdata = {25'b0, pt_q};
			rtpk_pkg::REG_SSRC:         prdata = ssrc_q;
			rtpk_pkg::REG_BYTES_PKT:    prdata = {20'b0, bpp_q};
			rtpk_pkg::REG_SAMPLES_PKT:  prdata = {20'b0, spp_q};
			default:                    prdata = '0;
		endcase
	end

	assign front_cfg.enable      = enable_q;
	assign front_cfg.pkt_bytes   = bpp_q;
	assign front_cfg.pkt_samples = spp_q;
	assign back_cfg.ptype        = pt_q;
	assign back_cfg.ssrc         = ssrc_q;

	// Input handshake.
	assign full   = q_full;
	assign accept = push && !q_full;

	rtpk_front #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.payload_byte(payload_byte),
		.buffer_first(buffer_first),
		.buffer_last (buffer_last),
		.ptp_valid   (ptp_valid),
		.ptp_time    (ptp_time),
		.cfg         (front_cfg),
		.wr_en       (wr_en),
		.wr_cmd      (wr_cmd)
	);

	rtpk_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_cmd (wr_cmd),
		.rd_en  (rd_en),
		.rd_cmd (head),
		.q_full (q_full),
		.q_empty(q_empty)
	);

	rtpk_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (back_cfg),
		.head        (head),
		.q_empty     (q_empty),
		.rd_en       (rd_en),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.header_byte (header_byte),
		.packet_end  (packet_end),
		.packet_abort(packet_abort)
	);

`ifndef SYNTH
	// An aborted packet is always closed by the same result.
	a_abort_has_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && packet_abort |-> packet_end)
		else $error("packet_abort without packet_end");

	// Header bytes never close a packet.
	a_hdr_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && header_byte |-> !packet_end)
		else $error("header byte marked as packet end");

	// The command queue cannot be full and empty at once.
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("command queue full and empty together");

	// The back end only reads the queue when it holds a command.
	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !q_empty)
		else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_rtp_audio_packetizer.sv =====
// Self-checking testbench for the RTP audio packetizer: directed cases, then random buffers.
// Depends on rtpk_pkg and rtp_audio_packetizer; predicts every header and payload byte.
`timescale 1ns / 100ps

module tb_rtp_audio_packetizer;

	localparam int          CYCLE_LIMIT    = 400000;
	localparam int          DRAIN_CYCLES   = 32;
	localparam int          RANDOM_ITEMS   = 160;
	localparam int          MAX_REPORTS    = 10;
	localparam logic [2:0]  REG_UNMAPPED_LO = 3'd5;
	localparam logic [2:0]  REG_UNMAPPED_HI = 3'd7;

	// One byte of the outgoing packet stream.
	typedef struct packed {
		logic [rtpk_pkg::BYTE_W-1:0] data;
		logic                        hdr;
		logic                        last;
		logic                        aborted;
	} rtp_byte_t;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          psel         = 1'b0;
	logic                          penable      = 1'b0;
	logic                          pwrite       = 1'b0;
	logic [rtpk_pkg::ADDR_W-1:0]   paddr        = '0;
	logic [rtpk_pkg::DATA_W-1:0]   pwdata       = '0;
	logic [rtpk_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          push         = 1'b0;
	logic                          full;
	logic [rtpk_pkg::BYTE_W-1:0]   payload_byte = '0;
	logic                          buffer_first = 1'b0;
	logic                          buffer_last  = 1'b0;
	logic                          ptp_valid    = 1'b0;
	logic [rtpk_pkg::TS_W-1:0]     ptp_time     = '0;
	logic                          empty;
	logic                          pop          = 1'b0;
	logic [rtpk_pkg::BYTE_W-1:0]   out_byte;
	logic                          header_byte;
	logic                          packet_end;
	logic                          packet_abort;

	// Register copies and packet state of the predictor.
	logic                          cfg_enable  = 1'b0;
	logic [rtpk_pkg::PT_W-1:0]     cfg_pt      = rtpk_pkg::PT_RESET;
	logic [rtpk_pkg::SSRC_W-1:0]   cfg_ssrc    = '0;
	logic [rtpk_pkg::CNT_W-1:0]    cfg_bytes   = rtpk_pkg::BYTES_RESET;
	logic [rtpk_pkg::CNT_W-1:0]    cfg_samples = rtpk_pkg::SAMPLES_RESET;
	logic [rtpk_pkg::SEQ_W-1:0]    seq_now     = '0;
	logic [rtpk_pkg::TS_W-1:0]     stamp_now   = '0;
	logic [rtpk_pkg::CNT_W-1:0]    fill_count  = '0;
	logic                          packet_open = 1'b0;

	rtp_byte_t    expected_stream[$];
	int           mismatch_count = 0;
	int           cycle_count    = 0;
	int unsigned  pop_hold       = 0;
	logic         push_steady    = 1'b0;
	logic         pop_steady     = 1'b0;

	rtp_audio_packetizer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.push         (push),
		.full         (full),
		.payload_byte (payload_byte),
		.buffer_first (buffer_first),
		.buffer_last  (buffer_last),
		.ptp_valid    (ptp_valid),
		.ptp_time     (ptp_time),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.header_byte  (header_byte),
		.packet_end   (packet_end),
		.packet_abort (packet_abort)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned draw_gap(logic steady);
		return steady ? 0 : $urandom_range(0, 12);
	endfunction

	// Random bits above the register width; the block must ignore them.
	function automatic logic [31:0] with_junk(int unsigned value, int unsigned width);
		return ($urandom() << width) | value;
	endfunction

	// Register write as seen by the predictor.
	function automatic void apply_register(logic [2:0] idx, logic [31:0] word);
		case (idx)
			rtpk_pkg::REG_ENABLE:       cfg_enable  = word[0];
			rtpk_pkg::REG_PAYLOAD_TYPE: cfg_pt      = word[rtpk_pkg::PT_W-1:0];
			rtpk_pkg::REG_SSRC:         cfg_ssrc    = word;
			rtpk_pkg::REG_BYTES_PKT:    cfg_bytes   = word[rtpk_pkg::CNT_W-1:0];
			rtpk_pkg::REG_SAMPLES_PKT:  cfg_samples = word[rtpk_pkg::CNT_W-1:0];
			default: ;
		endcase
	endfunction

	// Expected output bytes for one accepted item: a header when no packet is
	// open, then the payload byte with its end and abort marks; nothing while disabled.
	function automatic void packetize_byte(logic [7:0] b, logic first, logic last,
			logic pvalid, logic [31:0] ptime);
		logic [rtpk_pkg::HDR_BYTES*8-1:0] hdr_bits;
		logic [rtpk_pkg::CNT_W-1:0]       limit;
		if (!cfg_enable)
			return;
		if (!packet_open) begin
			if (first && pvalid)
				stamp_now = ptime;
			hdr_bits = {rtpk_pkg::RTP_BYTE0, 1'b0, cfg_pt, seq_now, stamp_now, cfg_ssrc};
			for (int i = 0; i < rtpk_pkg::HDR_BYTES; i++)
				expected_stream.push_back('{hdr_bits[95 - 8*i -: 8], 1'b1, 1'b0, 1'b0});
			packet_open = 1'b1;
			fill_count  = '0;
		end
		limit = (cfg_bytes == '0) ? 12'd1 : cfg_bytes;
		fill_count = fill_count + rtpk_pkg::CNT_W'(1);
		if (fill_count >= limit) begin
			expected_stream.push_back('{b, 1'b0, 1'b1, 1'b0});
			seq_now     = seq_now + rtpk_pkg::SEQ_W'(1);
			stamp_now   = stamp_now + {20'b0, cfg_samples};
			packet_open = 1'b0;
			fill_count  = '0;
		end else if (last) begin
			expected_stream.push_back('{b, 1'b0, 1'b1, 1'b1});
			packet_open = 1'b0;
			fill_count  = '0;
		end else begin
			expected_stream.push_back('{b, 1'b0, 1'b0, 1'b0});
		end
	endfunction

	task automatic flag_error(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("ERROR at %0t ns: %s", $time, what);
	endtask

	// Offer one item after a random gap and hold it until it is taken.
	task automatic send_byte(logic [7:0] b, logic first, logic last, logic pvalid,
			logic [31:0] ptime);
		int unsigned gap;
		gap = draw_gap(push_steady);
		@(negedge clk);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push         = 1'b1;
		payload_byte = b;
		buffer_first = first;
		buffer_last  = last;
		ptp_valid    = pvalid;
		ptp_time     = ptime;
		do @(posedge clk); while (full);
		packetize_byte(b, first, last, pvalid, ptime);
	endtask

	// Two-phase register write.
	task automatic write_reg(logic [2:0] idx, logic [31:0] word);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = word;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		apply_register(idx, word);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Stop offering items, collect every expected byte, then let dropped items clear.
	task automatic settle_idle();
		@(negedge clk);
		push = 1'b0;
		while (expected_stream.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Reset defaults: items dropped while disabled, then a header built from defaults.
	task automatic test_reset_defaults();
		send_byte(8'h11, 1'b1, 1'b0, 1'b1, 32'h0123_4567);
		send_byte(8'h22, 1'b0, 1'b1, 1'b0, 32'h0);
		settle_idle();
		write_reg(rtpk_pkg::REG_ENABLE, 32'd1);
		send_byte(8'hFF, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
		send_byte(8'h00, 1'b0, 1'b1, 1'b0, 32'h0);
	endtask

	// Zero size acting as one, top register values, timestamp wrap, size one with last.
	task automatic test_size_extremes();
		settle_idle();
		write_reg(rtpk_pkg::REG_PAYLOAD_TYPE, 32'd127);
		write_reg(rtpk_pkg::REG_SSRC, 32'hFFFF_FFFF);
		write_reg(rtpk_pkg::REG_BYTES_PKT, 32'd0);
		write_reg(rtpk_pkg::REG_SAMPLES_PKT, 32'd4095);
		send_byte(8'hA5, 1'b1, 1'b0, 1'b1, 32'hFFFF_F800);
		send_byte(8'h5A, 1'b0, 1'b0, 1'b0, 32'h0);
		settle_idle();
		write_reg(rtpk_pkg::REG_BYTES_PKT, 32'd1);
		send_byte(8'h3C, 1'b0, 1'b1, 1'b0, 32'h0);
	endtask

	// Buffer start inside an open packet, full together with last, start without PTP.
	task automatic test_buffer_marks();
		settle_idle();
		write_reg(rtpk_pkg::REG_PAYLOAD_TYPE, 32'd0);
		write_reg(rtpk_pkg::REG_SSRC, 32'd0);
		write_reg(rtpk_pkg::REG_BYTES_PKT, 32'd3);
		write_reg(rtpk_pkg::REG_SAMPLES_PKT, 32'd1);
		send_byte(8'h01, 1'b1, 1'b0, 1'b1, 32'h1234_5678);
		send_byte(8'h02, 1'b1, 1'b0, 1'b1, 32'hDEAD_BEEF);
		send_byte(8'h03, 1'b0, 1'b1, 1'b0, 32'h0);
		send_byte(8'h04, 1'b1, 1'b0, 1'b0, 32'hCAFE_F00D);
		send_byte(8'h05, 1'b0, 1'b1, 1'b0, 32'h0);
	endtask

	// A packet left open across a disabled stretch continues once re-enabled.
	task automatic test_pause_resume();
		settle_idle();
		write_reg(rtpk_pkg::REG_BYTES_PKT, 32'd4);
		write_reg(rtpk_pkg::REG_SAMPLES_PKT, 32'd2);
		send_byte(8'h10, 1'b1, 1'b0, 1'b1, 32'h8000_0000);
		send_byte(8'h20, 1'b0, 1'b0, 1'b0, 32'h0);
		settle_idle();
		write_reg(rtpk_pkg::REG_ENABLE, 32'd0);
		send_byte(8'h30, 1'b1, 1'b0, 1'b1, $urandom());
		send_byte(8'h40, 1'b0, 1'b1, 1'b1, $urandom());
		settle_idle();
		write_reg(rtpk_pkg::REG_ENABLE, 32'd1);
		send_byte(8'h50, 1'b1, 1'b0, 1'b1, 32'h7FFF_FFFF);
		send_byte(8'h60, 1'b0, 1'b0, 1'b0, 32'h0);
	endtask

	// Largest packet size, zero increment, and writes to unmapped addresses.
	task automatic test_largest_packet();
		settle_idle();
		write_reg(rtpk_pkg::REG_BYTES_PKT, 32'd4095);
		write_reg(rtpk_pkg::REG_SAMPLES_PKT, 32'd0);
		write_reg(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
		write_reg(REG_UNMAPPED_HI, 32'hFFFF_FFFF);
		send_byte(8'h80, 1'b1, 1'b0, 1'b1, 32'h0000_0001);
		send_byte(8'h7F, 1'b0, 1'b0, 1'b0, 32'h0);
		send_byte(8'hC3, 1'b0, 1'b1, 1'b0, 32'h0);
	endtask

	// Random settings per phase, mostly well-formed buffers with some noise items.
	task automatic test_random_traffic();
		int unsigned counted;
		int unsigned blen;
		int unsigned size;
		logic        pvalid;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			settle_idle();
			push_steady = ($urandom_range(0, 3) == 0);
			pop_steady  = ($urandom_range(0, 3) == 0);
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 12);
			write_reg(rtpk_pkg::REG_ENABLE, with_junk(32'($urandom_range(0, 7) != 0), 1));
			write_reg(rtpk_pkg::REG_PAYLOAD_TYPE, with_junk($urandom_range(0, 127), 7));
			write_reg(rtpk_pkg::REG_SSRC, $urandom());
			write_reg(rtpk_pkg::REG_BYTES_PKT, with_junk(size, 12));
			write_reg(rtpk_pkg::REG_SAMPLES_PKT, with_junk($urandom_range(0, 4095), 12));
			repeat ($urandom_range(2, 5)) begin
				blen = $urandom_range(1, 24);
				for (int k = 0; k < blen; k++) begin
					if ($urandom_range(0, 9) == 0) begin
						send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
					end else begin
						pvalid = (k == 0) ? ($urandom_range(0, 4) != 0) :
							1'($urandom_range(0, 1));
						send_byte(8'($urandom_range(0, 255)), k == 0, k == blen - 1, pvalid,
							$urandom());
					end
					counted++;
				end
			end
		end
		push_steady = 1'b0;
		pop_steady  = 1'b0;
	endtask

	// Receiver: hold pop low for the drawn number of cycles after each item.
	always @(negedge clk) begin
		if (pop_hold != 0) begin
			pop = 1'b0;
			pop_hold--;
		end else begin
			pop = 1'b1;
		end
	end

	// Compare each accepted output byte with the oldest expected one.
	always @(posedge clk) begin : check_output
		rtp_byte_t want;
		if (arst_n && pop && !empty) begin
			if (expected_stream.size() == 0) begin
				flag_error($sformatf("unexpected byte %h hdr %b end %b abort %b",
					out_byte, header_byte, packet_end, packet_abort));
			end else begin
				want = expected_stream.pop_front();
				if (out_byte !== want.data || header_byte !== want.hdr ||
						packet_end !== want.last || packet_abort !== want.aborted)
					flag_error($sformatf(
						"expected byte %h hdr %b end %b abort %b, got %h %b %b %b",
						want.data, want.hdr, want.last, want.aborted,
						out_byte, header_byte, packet_end, packet_abort));
			end
			pop_hold = draw_gap(pop_steady);
		end
	end

	// Watchdog on total run length.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("rtp_audio_packetizer test failed");
		$finish;
	end

	initial begin : main
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_size_extremes();
		test_buffer_marks();
		test_pause_resume();
		test_largest_packet();
		test_random_traffic();
		settle_idle();
		if (mismatch_count == 0 && expected_stream.size() == 0) begin
			$display("rtp_audio_packetizer test passed");
		end else begin
			$display("rtp_audio_packetizer test failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/rtpk_pkg.sv
design/rtpk_front.sv
design/rtpk_queue.sv
design/rtpk_back.sv
design/rtp_audio_packetizer.sv
tb/tb_rtp_audio_packetizer.sv
